// ===== hdl/lpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpp_pkg: shared definitions of the lidar point projector
// Field widths of the stream beats, the configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package lpp_pkg;

    localparam int COORD_W     = 32;
    localparam int INTENSITY_W = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int NEAR_W      = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X     = 3'd0,
        CFG_ROW_Y     = 3'd1,
        CFG_ROW_Z     = 3'd2,
        CFG_FOCAL     = 3'd3,
        CFG_PRINCIPAL = 3'd4,
        CFG_WIDTH     = 3'd5,
        CFG_HEIGHT    = 3'd6,
        CFG_NEAR      = 3'd7
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] ROW_X_RESET = 64'd16384;
    localparam logic [CFG_DATA_W-1:0] ROW_Y_RESET = 64'd1073741824;
    localparam logic [CFG_DATA_W-1:0] ROW_Z_RESET = 64'd70368744177664;
    localparam int IMG_W_RESET  = 1280;
    localparam int IMG_H_RESET  = 720;
    localparam logic [NEAR_W-1:0] NEAR_RESET = 31'd6554;

endpackage

// ===== hdl/lidar_point_projector.sv =====
// ----------------------------------------------------------------------------
// lidar_point_projector: rigid transform and pinhole projection of lidar points
// Moves each point into the camera frame, rejects points at or behind the near
// limit, projects the rest with the focal lengths and principal point, and
// tests and rounds the pixel against the image size.
// ----------------------------------------------------------------------------
// QB = max(PIXEL_BITS + 20, 33) is the number of quotient bits. The divider
// pipeline retires one quotient bit per stage, and one beat may enter every
// cycle, so throughput is one point per cycle while the output is not stalled.
// Reset clears every valid bit and loads the register reset values; the
// pipeline stalls as a whole only while a finished beat waits at the output.
module lidar_point_projector
    import lpp_pkg::*;
#(
    parameter int PIXEL_BITS      = 12,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, lowest bit up: point_x, point_y, point_z, point_intensity.
    input  logic [111:0]           s_tdata,
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, lowest bit up: pixel_u, pixel_v, camera_depth, echo_intensity,
    // then zero fill to whole bytes.
    output logic [((2*PIXEL_BITS+48+7)/8)*8-1:0] m_tdata,
    // m_tuser: hit.
    output logic                   m_tuser
);

    // Quotient bits: enough to tell every in-image pixel from a miss.
    localparam int QB     = (PIXEL_BITS + 20 > 33) ? PIXEL_BITS + 20 : 33;
    // Remainder width: holds the 64-bit numerator and the divisor shifted by QB.
    localparam int CW     = QB + 32;
    // Signed pixel width in Q.20 after adding the principal point.
    localparam int SW     = QB + 6;
    // Accumulator of the transform: three 48-bit products plus the translation.
    localparam int AW     = 52;
    localparam int OUT_W  = 2*PIXEL_BITS + 48;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [QB-1:0] quo;
        logic          neg;
        logic          ovf;
    } div_t;

    typedef struct packed {
        logic                    near_ok;
        logic [COORD_W-1:0]      depth;
        logic [INTENSITY_W-1:0]  intensity;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the block is idle; the block does not check.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] row_reg [3];
    logic [CFG_DATA_W-1:0] focal_reg;
    logic [CFG_DATA_W-1:0] principal_reg;
    logic [PIXEL_BITS-1:0] width_reg;
    logic [PIXEL_BITS-1:0] height_reg;
    logic [NEAR_W-1:0]     near_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]    <= ROW_X_RESET;
            row_reg[1]    <= ROW_Y_RESET;
            row_reg[2]    <= ROW_Z_RESET;
            focal_reg     <= '0;
            principal_reg <= '0;
            width_reg     <= PIXEL_BITS'(IMG_W_RESET);
            height_reg    <= PIXEL_BITS'(IMG_H_RESET);
            near_reg      <= NEAR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROW_X:     row_reg[0]    <= cfg_data;
                CFG_ROW_Y:     row_reg[1]    <= cfg_data;
                CFG_ROW_Z:     row_reg[2]    <= cfg_data;
                CFG_FOCAL:     focal_reg     <= cfg_data;
                CFG_PRINCIPAL: principal_reg <= cfg_data;
                CFG_WIDTH:     width_reg     <= cfg_data[PIXEL_BITS-1:0];
                CFG_HEIGHT:    height_reg    <= cfg_data[PIXEL_BITS-1:0];
                CFG_NEAR:      near_reg      <= cfg_data[NEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Every stage advances together; a bubble at
    // the output lets the whole line move even while the sink stalls.
    // ------------------------------------------------------------------
    logic adv;
    logic m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;

    // ------------------------------------------------------------------
    // Stage 1: the nine rotation products.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] pin [3];
    logic signed [47:0]        prod_next [3][3];
    logic signed [47:0]        prod_reg  [3][3];
    logic [INTENSITY_W-1:0]    int1_reg;
    logic                      vld1_reg;

    assign pin[0] = s_tdata[31:0];
    assign pin[1] = s_tdata[63:32];
    assign pin[2] = s_tdata[95:64];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[r][j] = $signed(row_reg[r][16*j +: 16]) * pin[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            int1_reg <= s_tdata[111:96];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum, translation, round half up to the point's fraction
    // bits and saturate to 32 bits.
    // ------------------------------------------------------------------
    logic signed [AW-1:0]      acc   [3];
    logic signed [AW-15:0]     shr   [3];
    logic [COORD_W-1:0]        cam_next [3];
    logic [COORD_W-1:0]        cam_reg  [3];
    logic [INTENSITY_W-1:0]    int2_reg;
    logic                      vld2_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]) + AW'(prod_reg[r][2])
                   + (AW'($signed(row_reg[r][63:48])) <<< (COORD_FRAC_BITS + 4))
                   + AW'(signed'(1 << 13));
            shr[r] = $signed(acc[r][AW-1:14]);
            if ((&shr[r][AW-15:31]) || !(|shr[r][AW-15:31])) begin
                cam_next[r] = shr[r][31:0];
            end else if (shr[r][AW-15]) begin
                cam_next[r] = 32'h8000_0000;
            end else begin
                cam_next[r] = 32'h7FFF_FFFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cam_reg  <= cam_next;
            int2_reg <= int1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: near test, magnitudes and signs of camera x and y.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] absu_reg, absv_reg;
    logic               negu_reg, negv_reg;
    side_t              side3_reg;
    logic               vld3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            negu_reg <= cam_reg[0][31];
            negv_reg <= cam_reg[1][31];
            absu_reg <= cam_reg[0][31] ? 32'(-cam_reg[0]) : cam_reg[0];
            absv_reg <= cam_reg[1][31] ? 32'(-cam_reg[1]) : cam_reg[1];
            side3_reg.near_ok   <= $signed({cam_reg[2][31], cam_reg[2]})
                                   > $signed({2'b00, near_reg});
            side3_reg.depth     <= cam_reg[2];
            side3_reg.intensity <= int2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: numerator magnitudes f * |c|.
    // ------------------------------------------------------------------
    logic [63:0] magu_reg, magv_reg;
    logic        negu4_reg, negv4_reg;
    side_t       side4_reg;
    logic        vld4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
        end else if (adv) begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            magu_reg  <= 64'(focal_reg[31:0])  * 64'(absu_reg);
            magv_reg  <= 64'(focal_reg[63:32]) * 64'(absv_reg);
            negu4_reg <= negu_reg;
            negv4_reg <= negv_reg;
            side4_reg <= side3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5 and the divider: overflow check, then one restoring step per
    // stage from the top quotient bit down. The divisor is the depth, which
    // is at least one for every point that passed the near test.
    // ------------------------------------------------------------------
    div_t  du_reg   [QB+1];
    div_t  dv_reg   [QB+1];
    side_t dside_reg [QB+1];
    logic  dvld_reg [QB+1];

    function automatic div_t div_step(input div_t d, input logic [30:0] den, input int sh);
        logic [CW:0] trial;
        div_t        r;
        r     = d;
        trial = {1'b0, d.rem} - ({1'b0, CW'(den)} << sh);
        if (!trial[CW]) begin
            r.rem = trial[CW-1:0];
            r.quo = d.quo | (QB'(1) << sh);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg[0] <= 1'b0;
        end else if (adv) begin
            dvld_reg[0] <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            du_reg[0].rem <= CW'(magu_reg);
            du_reg[0].quo <= '0;
            du_reg[0].neg <= negu4_reg;
            du_reg[0].ovf <= CW'(magu_reg) >= (CW'(side4_reg.depth[30:0]) << QB);
            dv_reg[0].rem <= CW'(magv_reg);
            dv_reg[0].quo <= '0;
            dv_reg[0].neg <= negv4_reg;
            dv_reg[0].ovf <= CW'(magv_reg) >= (CW'(side4_reg.depth[30:0]) << QB);
            dside_reg[0]  <= side4_reg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dvld_reg[k+1] <= dvld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                du_reg[k+1]    <= div_step(du_reg[k], dside_reg[k].depth[30:0], QB-1-k);
                dv_reg[k+1]    <= div_step(dv_reg[k], dside_reg[k].depth[30:0], QB-1-k);
                dside_reg[k+1] <= dside_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage 1: floor quotient with sign, plus the principal point.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] qmu, qmv, u20_next, v20_next;
    logic signed [SW-1:0] u20_reg, v20_reg;
    logic                 ovf_reg;
    side_t                sidef_reg;
    logic                 vldf_reg;

    always_comb begin
        qmu = SW'(du_reg[QB].quo) + SW'(du_reg[QB].neg && (|du_reg[QB].rem));
        qmv = SW'(dv_reg[QB].quo) + SW'(dv_reg[QB].neg && (|dv_reg[QB].rem));
        u20_next = (du_reg[QB].neg ? -qmu : qmu) + SW'({1'b0, principal_reg[31:0]});
        v20_next = (dv_reg[QB].neg ? -qmv : qmv) + SW'({1'b0, principal_reg[63:32]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vldf_reg <= 1'b0;
        end else if (adv) begin
            vldf_reg <= dvld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u20_reg   <= u20_next;
            v20_reg   <= v20_next;
            ovf_reg   <= du_reg[QB].ovf || dv_reg[QB].ovf;
            sidef_reg <= dside_reg[QB];
        end
    end

    // ------------------------------------------------------------------
    // Final stage 2: bound test on the unrounded pixel, round and clamp.
    // ------------------------------------------------------------------
    logic                  hit_next;
    logic signed [SW-1:0]  ru_sum, rv_sum;
    logic [PIXEL_BITS:0]   ru, rv, wm1, hm1;
    logic [PIXEL_BITS-1:0] pu_next, pv_next;

    logic                  hit_reg;
    logic [PIXEL_BITS-1:0] pu_reg, pv_reg;
    logic [COORD_W-1:0]    depth_reg;
    logic [INTENSITY_W-1:0] int_reg;

    always_comb begin
        hit_next = sidef_reg.near_ok && !ovf_reg && !u20_reg[SW-1] && !v20_reg[SW-1]
                 && (u20_reg < $signed(SW'({width_reg, 20'b0})))
                 && (v20_reg < $signed(SW'({height_reg, 20'b0})));
        ru_sum = u20_reg + SW'(signed'(1 << 19));
        rv_sum = v20_reg + SW'(signed'(1 << 19));
        ru  = ru_sum[PIXEL_BITS+20:20];
        rv  = rv_sum[PIXEL_BITS+20:20];
        wm1 = {1'b0, width_reg}  - (PIXEL_BITS+1)'(1);
        hm1 = {1'b0, height_reg} - (PIXEL_BITS+1)'(1);
        pu_next = '0;
        pv_next = '0;
        if (hit_next) begin
            pu_next = (ru > wm1) ? wm1[PIXEL_BITS-1:0] : ru[PIXEL_BITS-1:0];
            pv_next = (rv > hm1) ? hm1[PIXEL_BITS-1:0] : rv[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vldf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg   <= hit_next;
            pu_reg    <= pu_next;
            pv_reg    <= pv_next;
            depth_reg <= sidef_reg.depth;
            int_reg   <= sidef_reg.intensity;
        end
    end

    assign m_tdata = OUT_TW'({int_reg, depth_reg, pv_reg, pu_reg});
    assign m_tuser = hit_reg;

endmodule

// ===== hdl/lpp_checker.sv =====
// ----------------------------------------------------------------------------
// lpp_checker: port-level checks of the lidar point projector
// Watches the top level's ports and is bound to every instance.
// ----------------------------------------------------------------------------
module lpp_checker
    import lpp_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*PIXEL_BITS+48+7)/8)*8-1:0]  m_tdata,
    input logic                                  m_tuser
);

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // No output beat is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    // A miss carries a zero pixel.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[2*PIXEL_BITS-1:0] == '0)
        else $error("miss with nonzero pixel");

    // The input side is open whenever no beat waits at the output.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready && cfg_ready)
        else $error("input blocked with empty output");

endmodule

bind lidar_point_projector lpp_checker #(.PIXEL_BITS(PIXEL_BITS)) u_lpp_checker (.*);
